FILE: src/xrr_pkg.sv
// Shared types, constants and the xorshift step for the range random number generator.
package xrr_pkg;

   localparam int unsigned StateWidth = 64;
   localparam int unsigned ValueWidth = 32;
   localparam int unsigned SpanWidth  = ValueWidth + 1;
   localparam int unsigned StepCount  = StateWidth;
   localparam int unsigned CountWidth = $clog2(StepCount);

   localparam int unsigned ShiftA = 13;
   localparam int unsigned ShiftB = 7;
   localparam int unsigned ShiftC = 17;

   localparam logic [StateWidth-1:0] StateOne = StateWidth'(1);

   typedef enum logic [1:0] {
      CTRL_IDLE,
      CTRL_DIVIDE,
      CTRL_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic trivial;
      logic last_step;
   } dp_status_type;

   function automatic logic [StateWidth-1:0] xorshift_next(input logic [StateWidth-1:0] x);
      logic [StateWidth-1:0] a;
      logic [StateWidth-1:0] b;
      logic [StateWidth-1:0] c;
      a = x ^ (x << ShiftA);
      b = a ^ (a >> ShiftB);
      c = b ^ (b << ShiftC);
      return c;
   endfunction

endpackage

FILE: src/xrr_ctrl.sv
// Controller state machine sequencing request accept, remainder steps and result transfer.
module xrr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  xrr_pkg::dp_status_type status,
   output xrr_pkg::dp_cmd_type    cmd
);

   xrr_pkg::ctrl_state_type state_ff;
   xrr_pkg::ctrl_state_type state_in;
   logic                    out_valid_ff;
   logic                    out_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= xrr_pkg::CTRL_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         xrr_pkg::CTRL_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = status.trivial ? xrr_pkg::CTRL_EMIT : xrr_pkg::CTRL_DIVIDE;
            end
         end
         xrr_pkg::CTRL_DIVIDE: begin
            cmd.step = 1'b1;
            if (status.last_step) begin
               state_in = xrr_pkg::CTRL_EMIT;
            end
         end
         xrr_pkg::CTRL_EMIT: begin
            // load the output register once it is empty or being drained
            if (!out_valid_ff || rsp_tready) begin
               cmd.emit = 1'b1;
               state_in = xrr_pkg::CTRL_IDLE;
            end
         end
         default: begin
            state_in = xrr_pkg::CTRL_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;

endmodule

FILE: src/xrr_datapath.sv
// Datapath: generator state, bit-serial remainder unit and output data register.
module xrr_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [xrr_pkg::StateWidth-1:0]      csr_seed,
   input  logic [xrr_pkg::ValueWidth-1:0]      range_low,
   input  logic [xrr_pkg::ValueWidth-1:0]      range_high,
   input  xrr_pkg::dp_cmd_type                 cmd,
   output xrr_pkg::dp_status_type              status,
   output logic [xrr_pkg::ValueWidth-1:0]      random_value
);

   logic [xrr_pkg::StateWidth-1:0] state_ff;
   logic [xrr_pkg::StateWidth-1:0] state_in;
   logic [xrr_pkg::StateWidth-1:0] next_state;
   logic [xrr_pkg::StateWidth-1:0] dividend_ff;
   logic [xrr_pkg::StateWidth-1:0] dividend_in;
   logic [xrr_pkg::SpanWidth-1:0]  rem_ff;
   logic [xrr_pkg::SpanWidth-1:0]  rem_in;
   logic [xrr_pkg::SpanWidth-1:0]  span_ff;
   logic [xrr_pkg::SpanWidth-1:0]  span_in;
   logic [xrr_pkg::ValueWidth-1:0] low_ff;
   logic [xrr_pkg::ValueWidth-1:0] low_in;
   logic [xrr_pkg::CountWidth-1:0] cnt_ff;
   logic [xrr_pkg::CountWidth-1:0] cnt_in;
   logic [xrr_pkg::ValueWidth-1:0] out_data_ff;
   logic [xrr_pkg::ValueWidth-1:0] out_data_in;
   logic [xrr_pkg::SpanWidth:0]    trial;
   logic [xrr_pkg::SpanWidth:0]    diff;
   logic                           trivial;

   assign trivial    = (range_high <= range_low);
   assign next_state = xrr_pkg::xorshift_next(state_ff);
   assign trial      = {rem_ff, dividend_ff[xrr_pkg::StateWidth-1]};
   assign diff       = trial - {1'b0, span_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= xrr_pkg::StateOne;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      span_ff     <= span_in;
      low_ff      <= low_in;
      out_data_ff <= out_data_in;
   end

   always_comb begin
      state_in    = state_ff;
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      span_in     = span_ff;
      low_in      = low_ff;
      cnt_in      = cnt_ff;
      out_data_in = out_data_ff;
      if (csr_write) begin
         state_in = (csr_seed == '0) ? xrr_pkg::StateOne : csr_seed;
      end else if (cmd.load && !trivial) begin
         state_in = next_state;
      end
      if (cmd.load) begin
         // full range gives a span of 2^32, which the extra span bit holds
         dividend_in = next_state;
         rem_in      = '0;
         span_in     = {1'b0, range_high} - {1'b0, range_low} + xrr_pkg::SpanWidth'(1);
         low_in      = range_low;
         cnt_in      = '0;
      end
      if (cmd.step) begin
         dividend_in = {dividend_ff[xrr_pkg::StateWidth-2:0], 1'b0};
         rem_in      = diff[xrr_pkg::SpanWidth] ? trial[xrr_pkg::SpanWidth-1:0]
                                                : diff[xrr_pkg::SpanWidth-1:0];
         cnt_in      = cnt_ff + xrr_pkg::CountWidth'(1);
      end
      if (cmd.emit) begin
         out_data_in = low_ff + rem_ff[xrr_pkg::ValueWidth-1:0];
      end
   end

   assign status.trivial   = trivial;
   assign status.last_step = (cnt_ff == xrr_pkg::CountWidth'(xrr_pkg::StepCount - 1));
   assign random_value     = out_data_ff;

endmodule

FILE: src/xorshift64_range_rng_unit.sv
// A request whose range needs a draw passes through the DIVIDE state and then EMIT before its result is valid;
// when range_high <= range_low there is no draw, DIVIDE is skipped and the result is range_low.
// One request at a time is in work, held by the 64-step bit-serial remainder unit;
// the next request is taken while the previous result waits in the output register.
// Reset (synchronous, active high) loads the generator state with one and empties the output.
// Top level of the xorshift range random number generator.
module xorshift64_range_rng_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] range_low, [63:32] range_high
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] random_value
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [63:0] csr_data     // [63:0] seed
);

   xrr_pkg::dp_cmd_type    cmd;
   xrr_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   xrr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   xrr_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_write    (csr_valid && csr_ready),
      .csr_seed     (csr_data),
      .range_low    (req_tdata[31:0]),
      .range_high   (req_tdata[63:32]),
      .cmd          (cmd),
      .status       (status),
      .random_value (rsp_tdata)
   );

endmodule

FILE: src/xrr_checker.sv
// Port-level checker for the range random number generator, bound to the top level.
module xrr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [63:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // one request in work at a time
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // empty or single-value range taken with the output empty returns range_low
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid && (req_tdata[63:32] <= req_tdata[31:0])
      |-> ##2 (rsp_tvalid && rsp_tdata == $past(req_tdata[31:0], 2)))
      else $error("trivial range result wrong");

   // no result straight out of reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind xorshift64_range_rng_unit xrr_checker u_xrr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
